[design/cspan_pkg.sv]
// Shared types, widths and codes for the circle span rasterizer.
// No dependencies; every other design file imports this package.
package cspan_pkg;

  localparam int MAX_DIM_DEF    = 4096;
  localparam int MAX_RADIUS_DEF = 31;

  localparam int DIM_W     = 13;  // image_width / image_height
  localparam int RAD_W     = 5;   // circle_radius, half width
  localparam int COORD_W   = 14;  // signed centre coordinates
  localparam int OUT_W     = 12;  // row / column outputs
  localparam int OFF_W     = 26;  // byte offset
  localparam int SQ_W      = 10;  // radicand r*r - dy*dy
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int SQRT_STEPS = RAD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } cspan_reg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_SQRT,
    B_SPAN,
    B_EMIT
  } cspan_bstate_t;

  // Clamped configuration, as seen by front and back
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [RAD_W-1:0] radius;
  } cspan_cfg_t;

  // One queued circle: centre plus the clipped, non-empty row range
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [DIM_W-1:0]          y_lo;
    logic [DIM_W-1:0]          y_hi;
  } cspan_job_t;

  typedef struct packed {
    logic [OUT_W-1:0] row_index;
    logic [OUT_W-1:0] span_start;
    logic [OUT_W-1:0] span_end;
    logic             span_empty;
    logic [OFF_W-1:0] byte_offset;
    logic             last_span;
  } cspan_span_t;

endpackage

[design/cspan_ifs.sv]
// Channel interfaces of the circle span rasterizer: input, result, config.
// Depends on cspan_pkg for widths.
interface cspan_in_if;
  import cspan_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  modport source (output valid, center_x, center_y, input ready);
  modport sink   (input valid, center_x, center_y, output ready);
endinterface

interface cspan_out_if;
  import cspan_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] row_index;
  logic [OUT_W-1:0] span_start;
  logic [OUT_W-1:0] span_end;
  logic             span_empty;
  logic [OFF_W-1:0] byte_offset;
  logic             last_span;
  modport source (output valid, row_index, span_start, span_end, span_empty,
                  byte_offset, last_span, input ready);
  modport sink   (input valid, row_index, span_start, span_end, span_empty,
                  byte_offset, last_span, output ready);
endinterface

interface cspan_cfg_if;
  import cspan_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/circle_span_rasterizer.sv]
// Top level of the circle span rasterizer: config registers, front, queue, back.
// Depends on cspan_pkg, cspan_ifs, cspan_front, cspan_queue, cspan_back.
//
// Each accepted centre (center_x, center_y, two's complement, may be off image)
// yields one span per image row from max(0, cy-r) to min(h-1, cy+r), top row
// first, the final one flagged by last_span; a centre with no rows on the image
// yields nothing. Each span gives the clipped first/last column and the byte
// offset (row*width+start)*3 of its first pixel in a 3-byte RGB frame; a row
// whose clipped span is empty is still reported with span_empty set and zero
// start, end and offset. Per row the back end steps through B_LOAD (form
// r*r-dy*dy), B_SQRT (bit-serial square root), B_SPAN (clipping and the
// row*width multiply) and B_EMIT (load the output register once it is
// free); from B_IDLE it picks up the next circle. A two-entry queue lets
// the front take further centres meanwhile, and the output register holds
// a span until transferred. Config writes (index 0 width, 1 height, 2 radius;
// other indexes ignored) are always ready and must only be issued while the
// block is idle. Width/height of 0 act as 1, values above MAX_DIM act as
// MAX_DIM, and the radius saturates at MAX_RADIUS.
module circle_span_rasterizer #(
  parameter int MAX_DIM    = cspan_pkg::MAX_DIM_DEF,
  parameter int MAX_RADIUS = cspan_pkg::MAX_RADIUS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  cspan_in_if.sink     in_ch,
  cspan_out_if.source  out_ch,
  cspan_cfg_if.sink    cfg_ch
);
  import cspan_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [RAD_W-1:0] radius_r;
  cspan_cfg_t       cfg_eff;

  cspan_job_t  push_job, head_job;
  logic        push, pop, q_full, q_empty;
  cspan_span_t span;

  // config port never stalls
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1024);
      height_r <= DIM_W'(1024);
      radius_r <= RAD_W'(2);
    end else if (cfg_ch.valid) begin
      case (cspan_reg_t'(cfg_ch.index))
        REG_WIDTH:  width_r  <= cfg_ch.data;
        REG_HEIGHT: height_r <= cfg_ch.data;
        REG_RADIUS: radius_r <= cfg_ch.data[RAD_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // clamp dims to [1, MAX_DIM], radius to MAX_RADIUS
  always_comb begin
    if (width_r == '0) begin
      cfg_eff.width = DIM_W'(1);
    end else if (int'(width_r) > MAX_DIM) begin
      cfg_eff.width = DIM_W'(MAX_DIM);
    end else begin
      cfg_eff.width = width_r;
    end
    if (height_r == '0) begin
      cfg_eff.height = DIM_W'(1);
    end else if (int'(height_r) > MAX_DIM) begin
      cfg_eff.height = DIM_W'(MAX_DIM);
    end else begin
      cfg_eff.height = height_r;
    end
    if (int'(radius_r) > MAX_RADIUS) begin
      cfg_eff.radius = RAD_W'(MAX_RADIUS);
    end else begin
      cfg_eff.radius = radius_r;
    end
  end

  cspan_front u_front (
    .cfg      (cfg_eff),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .center_x (in_ch.center_x),
    .center_y (in_ch.center_y),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  cspan_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  cspan_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_eff),
    .job       (head_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_span  (span)
  );

  assign out_ch.row_index   = span.row_index;
  assign out_ch.span_start  = span.span_start;
  assign out_ch.span_end    = span.span_end;
  assign out_ch.span_empty  = span.span_empty;
  assign out_ch.byte_offset = span.byte_offset;
  assign out_ch.last_span   = span.last_span;

endmodule

[design/cspan_front.sv]
// Front end: accepts centres, clips the row range, drops circles with no row on the image.
// Depends on cspan_pkg.
module cspan_front (
  input  cspan_pkg::cspan_cfg_t                      cfg,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [cspan_pkg::COORD_W-1:0]       center_x,
  input  logic signed [cspan_pkg::COORD_W-1:0]       center_y,
  input  logic                                       q_full,
  output logic                                       push,
  output cspan_pkg::cspan_job_t                      job
);
  import cspan_pkg::*;

  logic signed [COORD_W:0] cy_s;
  logic signed [COORD_W:0] r_s;
  logic signed [COORD_W:0] lo_s;
  logic signed [COORD_W:0] hi_s;
  logic signed [COORD_W:0] hmax_s;
  logic signed [COORD_W:0] ylo_s;
  logic signed [COORD_W:0] yhi_s;
  logic                    has_rows;

  always_comb begin
    cy_s   = {center_y[COORD_W-1], center_y};
    r_s    = {{(COORD_W+1-RAD_W){1'b0}}, cfg.radius};
    lo_s   = cy_s - r_s;
    hi_s   = cy_s + r_s;
    hmax_s = {{(COORD_W+1-DIM_W){1'b0}}, cfg.height} - 1'sd1;
    ylo_s  = (lo_s < 0) ? '0 : lo_s;
    yhi_s  = (hi_s > hmax_s) ? hmax_s : hi_s;
    has_rows = (ylo_s <= yhi_s);

    in_ready = !q_full;
    push     = in_valid && !q_full && has_rows;

    job.cx   = center_x;
    job.cy   = center_y;
    job.y_lo = ylo_s[DIM_W-1:0];
    job.y_hi = yhi_s[DIM_W-1:0];
  end

endmodule

[design/cspan_queue.sv]
// Short job queue between front and back so each side stalls on its own.
// Depends on cspan_pkg.
module cspan_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cspan_pkg::cspan_job_t push_job,
  input  logic                  pop,
  output cspan_pkg::cspan_job_t head,
  output logic                  full,
  output logic                  empty
);
  import cspan_pkg::*;

  cspan_job_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

[design/cspan_back.sv]
// Back end: walks the rows of one circle, bit-serial isqrt per row, clips
// the span and computes the RGB byte offset. Depends on cspan_pkg.
module cspan_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cspan_pkg::cspan_cfg_t cfg,
  input  cspan_pkg::cspan_job_t job,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cspan_pkg::cspan_span_t out_span
);
  import cspan_pkg::*;

  localparam int BIT_W = $clog2(SQRT_STEPS);

  cspan_bstate_t             state_r, state_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt;
  logic signed [COORD_W-1:0] cy_r, cy_nxt;
  logic [DIM_W-1:0]          y_r, y_nxt;
  logic [DIM_W-1:0]          yhi_r, yhi_nxt;
  logic [SQ_W-1:0]           rad_r, rad_nxt;
  logic [RAD_W-1:0]          root_r, root_nxt;
  logic [BIT_W-1:0]          bit_r, bit_nxt;
  logic [DIM_W-1:0]          x0_r, x0_nxt;
  logic [DIM_W-1:0]          x1_r, x1_nxt;
  logic                      empty_r, empty_nxt;
  logic [OFF_W-1:0]          prod_r, prod_nxt;
  cspan_span_t               out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // scratch
  logic signed [COORD_W:0]   dy_full;
  logic signed [RAD_W:0]     dy;
  logic signed [2*RAD_W+1:0] dy_sq;
  logic [SQ_W-1:0]           r_sq;
  logic [RAD_W-1:0]          trial;
  logic [SQ_W-1:0]           trial_sq;
  logic signed [COORD_W:0]   x0_s, x1_s, wmax_s, x0_c, x1_c;
  logic [OFF_W-1:0]          pix_idx;
  logic                      out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    y_nxt         = y_r;
    yhi_nxt       = yhi_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    empty_nxt     = empty_r;
    prod_nxt      = prod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop           = 1'b0;

    dy_full  = {{(COORD_W+1-DIM_W){1'b0}}, y_r} - {cy_r[COORD_W-1], cy_r};
    dy       = dy_full[RAD_W:0];  // |dy| <= radius by construction
    dy_sq    = dy * dy;
    r_sq     = SQ_W'(cfg.radius) * SQ_W'(cfg.radius);
    trial    = root_r | (RAD_W'(1) << bit_r);
    trial_sq = SQ_W'(trial) * SQ_W'(trial);

    x0_s   = {cx_r[COORD_W-1], cx_r} - {{(COORD_W+1-RAD_W){1'b0}}, root_r};
    x1_s   = {cx_r[COORD_W-1], cx_r} + {{(COORD_W+1-RAD_W){1'b0}}, root_r};
    wmax_s = {{(COORD_W+1-DIM_W){1'b0}}, cfg.width} - 1'sd1;
    x0_c   = (x0_s < 0) ? '0 : x0_s;
    x1_c   = (x1_s > wmax_s) ? wmax_s : x1_s;

    pix_idx = prod_r + OFF_W'(x0_r);

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cx_nxt    = job.cx;
          cy_nxt    = job.cy;
          y_nxt     = job.y_lo;
          yhi_nxt   = job.y_hi;
          state_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        rad_nxt   = r_sq - dy_sq[SQ_W-1:0];
        root_nxt  = '0;
        bit_nxt   = BIT_W'(SQRT_STEPS - 1);
        state_nxt = B_SQRT;
      end
      B_SQRT: begin
        if (trial_sq <= rad_r) begin
          root_nxt = trial;
        end
        if (bit_r == '0) begin
          state_nxt = B_SPAN;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      B_SPAN: begin
        x0_nxt    = x0_c[DIM_W-1:0];
        x1_nxt    = x1_c[DIM_W-1:0];
        empty_nxt = (x0_c > x1_c);
        prod_nxt  = OFF_W'(y_r) * OFF_W'(cfg.width);
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.row_index  = y_r[OUT_W-1:0];
          out_nxt.span_empty = empty_r;
          out_nxt.span_start = empty_r ? '0 : x0_r[OUT_W-1:0];
          out_nxt.span_end   = empty_r ? '0 : x1_r[OUT_W-1:0];
          out_nxt.byte_offset = empty_r ? '0 : pix_idx + {pix_idx[OFF_W-2:0], 1'b0};
          out_nxt.last_span  = (y_r == yhi_r);
          if (y_r == yhi_r) begin
            state_nxt = B_IDLE;
          end else begin
            y_nxt     = y_r + 1'b1;
            state_nxt = B_LOAD;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    y_r     <= y_nxt;
    yhi_r   <= yhi_nxt;
    rad_r   <= rad_nxt;
    root_r  <= root_nxt;
    bit_r   <= bit_nxt;
    x0_r    <= x0_nxt;
    x1_r    <= x1_nxt;
    empty_r <= empty_nxt;
    prod_r  <= prod_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_span  = out_r;

`ifndef SYNTHESIS
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SPAN) |->
      ((SQ_W'(root_r) * SQ_W'(root_r) <= rad_r) &&
       ((12'(root_r) + 12'd1) * (12'(root_r) + 12'd1) > 12'(rad_r))))
    else $error("half width is not floor sqrt");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.span_empty) |->
      (out_r.span_start == '0 && out_r.span_end == '0 && out_r.byte_offset == '0))
    else $error("empty span carries nonzero fields");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> (y_r <= yhi_r))
    else $error("row walked past last row");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for circle_span_rasterizer: drives circle centres and
// register writes, predicts every span in SV and checks each result transfer.
// Depends on cspan_pkg and the cspan_*_if interfaces from the design folder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cspan_pkg::*;

  // write to this index must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int IDLE_PCT      = 21;
  localparam int SETTLE_CYCLES = 32;           // lets a centre with no rows clear the front
  localparam int END_CYCLES    = 8 * 63 + 16; // one full circle of the largest radius
  localparam int HOLD_CYCLES   = 400;          // long output hold-off in the pressure test
  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int MAX_REPORTS   = 10;

  logic clk = 1'b0;
  logic rst_n;

  cspan_in_if  in_if ();
  cspan_out_if out_if ();
  cspan_cfg_if cfg_if ();

  circle_span_rasterizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #10 clk = ~clk;

  // Register shadows, written as the block sees them (raw, before clamping)
  logic [DIM_W-1:0] img_width_reg  = 13'd1024;
  logic [DIM_W-1:0] img_height_reg = 13'd1024;
  logic [RAD_W-1:0] radius_reg     = 5'd2;

  // Spans still owed by the block, oldest first
  cspan_span_t span_q[$];

  bit idle_on = 1'b1;
  int hold_req;
  int hold_left;
  int cycles;
  int mismatches;
  int centres_sent;
  int blank_centres;
  int spans_seen;
  int empty_seen;
  int in_stalls;
  int settings;

  // ---------------------------------------------------------------------------
  // Span prediction
  // ---------------------------------------------------------------------------
  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  function automatic int floor_sqrt(input int v);
    int s;
    s = 0;
    while ((s + 1) * (s + 1) <= v) s++;
    return s;
  endfunction

  // Appends the spans of one circle, top row first, to span_q
  function automatic void queue_circle_spans(input logic signed [COORD_W-1:0] cx_f,
                                             input logic signed [COORD_W-1:0] cy_f);
    int cx, cy, w, h, r, rr, top, bottom, y, dy, half, x0, x1;
    cspan_span_t s;
    cx = int'(cx_f);
    cy = int'(cy_f);
    w  = clamp_dim(img_width_reg);
    h  = clamp_dim(img_height_reg);
    r  = int'(radius_reg);
    if (r > MAX_RADIUS_DEF) r = MAX_RADIUS_DEF;
    rr = r * r;
    top = cy - r;
    if (top < 0) top = 0;
    bottom = cy + r;
    if (bottom > h - 1) bottom = h - 1;
    if (top > bottom) blank_centres++;
    for (y = top; y <= bottom; y++) begin
      dy   = y - cy;
      half = floor_sqrt(rr - dy * dy);
      x0   = cx - half;
      x1   = cx + half;
      if (x0 < 0) x0 = 0;
      if (x1 > w - 1) x1 = w - 1;
      s.row_index = OUT_W'(y);
      if (x0 > x1) begin
        // row is on the image but its clipped span holds no pixel
        s.span_start  = '0;
        s.span_end    = '0;
        s.span_empty  = 1'b1;
        s.byte_offset = '0;
      end else begin
        s.span_start  = OUT_W'(x0);
        s.span_end    = OUT_W'(x1);
        s.span_empty  = 1'b0;
        s.byte_offset = OFF_W'((y * w + x0) * 3);
      end
      s.last_span = (y == bottom);
      span_q.insert(span_q.size(), s);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: receiver ready with random idling and counted hold-offs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on) begin
      out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Each span transfer is checked field by field against the oldest prediction
  always @(posedge clk) begin : span_checker
    cspan_span_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.row_index   = out_if.row_index;
      got.span_start  = out_if.span_start;
      got.span_end    = out_if.span_end;
      got.span_empty  = out_if.span_empty;
      got.byte_offset = out_if.byte_offset;
      got.last_span   = out_if.last_span;
      spans_seen++;
      if (got.span_empty) empty_seen++;
      if (span_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] span with none pending: row %0d start %0d end %0d", $realtime,
                   got.row_index, got.span_start, got.span_end);
      end else begin
        want = span_q.pop_front();
        if (got.row_index !== want.row_index || got.span_start !== want.span_start ||
            got.span_end !== want.span_end || got.span_empty !== want.span_empty ||
            got.byte_offset !== want.byte_offset || got.last_span !== want.last_span) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] span mismatch  exp: row %0d start %0d end %0d empty %0b off %0d last %0b",
                     $realtime, want.row_index, want.span_start, want.span_end,
                     want.span_empty, want.byte_offset, want.last_span);
            $display("                      got: row %0d start %0d end %0d empty %0b off %0d last %0b",
                     got.row_index, got.span_start, got.span_end,
                     got.span_empty, got.byte_offset, got.last_span);
          end
        end
      end
    end
  end

  // Input stall counter, mostly to confirm the pressure test filled the block
  always @(posedge clk) begin
    if (rst_n && in_if.valid && !in_if.ready) in_stalls++;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d spans still pending", cycles, span_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------
  // One centre transfer. Valid stays high on return so back-to-back items
  // need no extra edge; it only drops when the sender decides to idle.
  task automatic send_centre(input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_if.valid    <= 1'b1;
    in_if.center_x <= cx;
    in_if.center_y <= cy;
    do @(posedge clk); while (!in_if.ready);
    centres_sent++;
    queue_circle_spans(cx, cy);
  endtask

  // Sender pauses until every predicted span has been transferred
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_WIDTH:  img_width_reg  = val;
      REG_HEIGHT: img_height_reg = val;
      REG_RADIUS: radius_reg     = val[RAD_W-1:0];
      default: ;  // unmapped index, no effect
    endcase
  endtask

  // Full register setting, only ever issued with the block idle.
  // Radius data carries junk above bit 4, which the block must drop.
  task automatic configure(input int w, input int h, input int r, input bit spare);
    wait_drained();
    write_reg(REG_WIDTH, DIM_W'(w));
    write_reg(REG_HEIGHT, DIM_W'(h));
    write_reg(REG_RADIUS, {8'($urandom_range(255)), 5'(r)});
    if (spare) write_reg(REG_SPARE, DIM_W'($urandom));
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input int lo, input int hi);
    int v;
    v = lo + int'($urandom_range(hi - lo));
    if (v < -8192) v = -8192;
    if (v > 8191) v = 8191;
    return COORD_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset register values: interior, corners, empty spans left of the image,
  // and centres with no row on the image at all
  task automatic test_reset_values();
    send_centre(14'sd100, 14'sd100);
    send_centre(14'sd0, 14'sd0);
    send_centre(14'sd1023, 14'sd1023);
    send_centre(-14'sd3, 14'sd5);      // every row clipped away to nothing
    send_centre(-14'sd3, -14'sd2);     // single row, and it is empty
    send_centre(-14'sd8192, -14'sd8192);
    send_centre(14'sd8191, 14'sd8191);
  endtask

  // Dimension clamping at both ends, radius extremes, junk radius bits and
  // the unmapped register index
  task automatic test_register_extremes();
    configure(0, 0, 31, 1'b0);         // 1x1 frame
    send_centre(14'sd0, 14'sd0);
    send_centre(14'sd5, -14'sd31);
    send_centre(-14'sd20, 14'sd10);
    configure(8191, 8191, 31, 1'b1);   // both dims clamp to the maximum
    send_centre(14'sd4095, 14'sd4095);
    send_centre(14'sd4100, 14'sd4090);
    send_centre(-14'sd31, 14'sd0);
    configure(4097, 4096, 0, 1'b0);    // zero radius: at most one pixel per centre
    send_centre(14'sd2000, 14'sd4095);
    send_centre(14'sd4096, 14'sd10);
    send_centre(14'sd0, -14'sd1);
    configure(1, 4096, 5, 1'b1);       // one column wide
    send_centre(14'sd0, 14'sd2000);
    send_centre(-14'sd5, 14'sd7);
  endtask

  // Random settings per phase; centres mostly land near the frame so that
  // clipping on all four sides is common, the rest span the whole field
  task automatic test_random_traffic();
    int p, n, w, h, r, wc, hc;
    for (p = 0; p < 8; p++) begin
      if (p % 4 == 2) begin
        w = $urandom_range(3000, 8191);
        h = $urandom_range(3000, 8191);
      end else begin
        w = $urandom_range(0, 48);
        h = $urandom_range(0, 48);
      end
      r = (p == 0) ? 31 : (p == 1) ? 0 : $urandom_range(0, 31);
      configure(w, h, r, $urandom_range(1));
      // long stretch with no idling on either side
      idle_on <= (p != 4);
      wc = clamp_dim(DIM_W'(w));
      hc = clamp_dim(DIM_W'(h));
      for (n = 0; n < 32; n++) begin
        if ($urandom_range(99) < 15)
          send_centre(COORD_W'($urandom), COORD_W'($urandom));
        else
          send_centre(pick_coord(-r - 3, wc + r + 2), pick_coord(-r - 3, hc + r + 2));
        if ($urandom_range(99) < 4) wait_drained();
      end
    end
    idle_on <= 1'b1;
  endtask

  // Output held off while centres keep coming: queue and output register
  // fill and the input must stall, then everything drains
  task automatic test_backpressure();
    int n;
    configure(64, 64, 12, 1'b0);
    idle_on <= 1'b0;
    @(negedge clk);
    hold_req = HOLD_CYCLES;
    @(posedge clk);
    for (n = 0; n < 8; n++)
      send_centre(pick_coord(0, 63), pick_coord(0, 63));
    wait_drained();
    idle_on <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.center_x  = '0;
    in_if.center_y  = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_WIDTH;
    cfg_if.data     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);

    $display("Ran %0d centres over %0d register settings: %0d spans, %0d empty, %0d centres off frame.",
             centres_sent, settings, spans_seen, empty_seen, blank_centres);
    $display("Output held off for %0d cycles once; input stalled %0d cycles in total.",
             HOLD_CYCLES, in_stalls);
    if (mismatches == 0 && span_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d spans never seen", mismatches, span_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/cspan_pkg.sv
design/cspan_ifs.sv
design/cspan_front.sv
design/cspan_queue.sv
design/cspan_back.sv
design/circle_span_rasterizer.sv
tb/tb_top.sv
